[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_BITS = 16;
  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_INSERT = 2'd1,
    FSM_DONE   = 2'd2
  } fsm_t;

  typedef struct packed {
    logic capture;
    logic do_insert;
    logic do_remove_head;
    logic do_remove_match;
    logic load_result;
  } spq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic found;
  } spq_stat_t;

endpackage

[rtl/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath
// Row of slot registers with parallel compare, insert shift and remove shift.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spq_pkg::spq_cmd_t             cmd,
  output spq_pkg::spq_stat_t            stat,
  input  logic [spq_pkg::ID_BITS-1:0]   in_id,
  input  logic signed [31:0]            in_prio,
  input  logic [1:0]                    in_status,
  output logic [1:0]                    out_status,
  output logic [15:0]                   out_popped_id,
  output logic [15:0]                   out_head_id,
  output logic [15:0]                   out_tail_id,
  output logic [6:0]                    out_entry_total,
  output logic                          out_is_empty
);

  localparam int N = spq_pkg::CAPACITY;

  logic [spq_pkg::ID_BITS-1:0] ids_r [N];
  logic [spq_pkg::ID_BITS-1:0] ids_nxt [N];
  logic signed [31:0]          pri_r [N];
  logic signed [31:0]          pri_nxt [N];
  logic [spq_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [spq_pkg::ID_BITS-1:0] id_r;
  logic signed [31:0]          prio_r;
  logic [N-1:0] valid, gt, hit, hit_first, after_hit;
  logic [15:0]  popped_r;
  logic [spq_pkg::ID_BITS-1:0] tail_sel;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      valid[i] = (i < int'(cnt_r));
      gt[i]    = valid[i] && (pri_r[i] > prio_r);
      hit[i]   = valid[i] && (ids_r[i] == id_r);
    end
    after_hit[0] = 1'b0;
    for (int i = 1; i < N; i++) after_hit[i] = after_hit[i-1] | hit[i-1];
    hit_first = hit & ~after_hit;
  end

  assign stat.full  = (cnt_r == spq_pkg::CNT_BITS'(N));
  assign stat.empty = (cnt_r == '0);
  assign stat.found = |hit;

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < N; i++) begin
      ids_nxt[i] = ids_r[i];
      pri_nxt[i] = pri_r[i];
    end
    if (cmd.do_insert) begin
      cnt_nxt = cnt_r + 1'b1;
      if (gt[0] || cnt_r == '0) begin
        ids_nxt[0] = id_r;
        pri_nxt[0] = prio_r;
      end
      for (int i = 1; i < N; i++) begin
        if (gt[i] || i == int'(cnt_r)) begin
          if (gt[i-1]) begin
            ids_nxt[i] = ids_r[i-1];
            pri_nxt[i] = pri_r[i-1];
          end else begin
            ids_nxt[i] = id_r;
            pri_nxt[i] = prio_r;
          end
        end
      end
    end else if (cmd.do_remove_head || cmd.do_remove_match) begin
      cnt_nxt = cnt_r - 1'b1;
      for (int i = 0; i < N - 1; i++) begin
        if (cmd.do_remove_head || after_hit[i] || hit_first[i]) begin
          ids_nxt[i] = ids_r[i+1];
          pri_nxt[i] = pri_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      ids_r[i] <= ids_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
    if (cmd.capture) begin
      id_r   <= in_id;
      prio_r <= in_prio;
    end
    if (cmd.capture) popped_r <= '0;
    else if (cmd.do_remove_head) popped_r <= 16'(ids_r[0]);
  end

  assign tail_sel = ids_r[spq_pkg::IDX_BITS'(cnt_r - 1'b1)];

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_status      <= in_status;
      out_popped_id   <= popped_r;
      out_head_id     <= (cnt_r == '0) ? 16'd0 : 16'(ids_r[0]);
      out_tail_id     <= (cnt_r == '0) ? 16'd0 : 16'(tail_sel);
      out_entry_total <= 7'(cnt_r);
      out_is_empty    <= (cnt_r == '0);
    end
  end

endmodule

[rtl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for push, pop and update requests and the result handshake.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  output logic               out_valid,
  input  logic               out_ready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd,
  output logic [1:0]         status_code
);

  spq_pkg::fsm_t    state_r, state_nxt;
  spq_pkg::req_t    req_r;
  spq_pkg::status_t status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             pend_r, pend_nxt;
  logic             accept;
  logic             can_load;

  assign accept      = in_valid && in_ready;
  assign in_ready    = (state_r == spq_pkg::FSM_IDLE) && !pend_r;
  assign out_valid   = out_valid_r;
  assign status_code = status_r;
  assign can_load    = (state_r == spq_pkg::FSM_DONE) && !pend_r && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spq_pkg::FSM_IDLE:   if (accept) state_nxt = spq_pkg::FSM_INSERT;
      spq_pkg::FSM_INSERT: state_nxt = spq_pkg::FSM_DONE;
      spq_pkg::FSM_DONE:   if (can_load) state_nxt = spq_pkg::FSM_IDLE;
      default:             state_nxt = spq_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.capture = accept;
    unique case (state_r)
      spq_pkg::FSM_IDLE: ;
      spq_pkg::FSM_INSERT: begin
        unique case (req_r)
          spq_pkg::REQ_PUSH:   cmd.do_insert = !stat.full;
          spq_pkg::REQ_POP:    cmd.do_remove_head = !stat.empty;
          spq_pkg::REQ_UPDATE: cmd.do_remove_match = stat.found;
          default: ;
        endcase
      end
      spq_pkg::FSM_DONE: begin
        cmd.do_insert   = (req_r == spq_pkg::REQ_UPDATE) && pend_r;
        cmd.load_result = can_load;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_nxt = status_r;
    if (accept) begin
      unique case (spq_pkg::req_t'(in_req_type))
        spq_pkg::REQ_PUSH: status_nxt = stat.full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        spq_pkg::REQ_POP:  status_nxt = stat.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
        default:           status_nxt = spq_pkg::ST_OK;
      endcase
    end
    if (state_r == spq_pkg::FSM_INSERT && req_r == spq_pkg::REQ_UPDATE && !stat.found)
      status_nxt = spq_pkg::ST_NOT_FOUND;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (can_load) out_valid_nxt = 1'b1;
    pend_nxt = pend_r;
    if (state_r == spq_pkg::FSM_INSERT) pend_nxt = cmd.do_remove_match;
    if (state_r == spq_pkg::FSM_DONE) pend_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::FSM_IDLE;
      status_r    <= spq_pkg::ST_OK;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= spq_pkg::req_t'(in_req_type);
  end

endmodule

[rtl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted list priority queue with push, pop and update of an id.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one request: in_req_type,
// in_node_id, in_priority_req. Result channel out_valid/out_ready carries
// one result per request: status, popped id, head id, tail id, count, empty.
// Entries live in a row of slot registers; every slot compares against the
// request in parallel, so an insert or a remove is one register update.
// After acceptance the request takes one remove or insert step, then the
// result load; an update that moves an entry adds its insert step before
// the load. No new request is accepted until the result of the last one
// is loaded and the sequencer is back in its idle step.
// The result is held in an output register; while the receiver stalls one
// more request is accepted and processed, then the sequencer waits in its
// final step and accepts no new request.
// Reset clears the count and all handshake state; slot contents are not
// cleared and are never used above the count.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [15:0]        in_node_id,
  input  logic signed [31:0] in_priority_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [15:0]        out_popped_id,
  output logic [15:0]        out_head_id,
  output logic [15:0]        out_tail_id,
  output logic [6:0]         out_entry_total,
  output logic               out_is_empty
);

  spq_pkg::spq_cmd_t  cmd;
  spq_pkg::spq_stat_t stat;
  logic [1:0] status_code;

  spq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd), .status_code(status_code)
  );

  spq_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_id(in_node_id[spq_pkg::ID_BITS-1:0]), .in_prio(in_priority_req),
    .in_status(status_code), .out_status(out_status),
    .out_popped_id(out_popped_id), .out_head_id(out_head_id),
    .out_tail_id(out_tail_id), .out_entry_total(out_entry_total),
    .out_is_empty(out_is_empty)
  );

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.do_insert, cmd.do_remove_head, cmd.do_remove_match}) <= 1)
    else $error("datapath got more than one slot command");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ready)
    else $error("request accepted while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_total <= 7'(spq_pkg::CAPACITY))
    else $error("count beyond capacity");

endmodule
